/* rtl/core/pfa_pkg.sv */
// Shared types, constants and handshake structs for the page frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

   localparam int FRAMES   = 16;
   localparam int MAX_BEAT = 16;
   localparam int REPORTED = (FRAMES < MAX_BEAT) ? FRAMES : MAX_BEAT;
   localparam int IDX_W    = $clog2(FRAMES);
   localparam int CNT_W    = $clog2(FRAMES + 1);
   localparam int WANT_W   = 5;
   localparam int CMP_W    = (CNT_W > WANT_W) ? CNT_W : WANT_W;
   localparam int MASK_W   = 16;

   localparam logic [1:0] CMD_DUMP   = 2'd0;
   localparam logic [1:0] CMD_ERASE  = 2'd1;
   localparam logic [1:0] CMD_ALLOC  = 2'd2;
   localparam logic [1:0] CMD_LOCATE = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        process_id;
      logic [WANT_W-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [3:0]        frame_index;
      logic [7:0]        owner;
      logic [MASK_W-1:0] frame_mask;
      logic              last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic count_step;
      logic walk_step;
      logic dump_load;
      logic final_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       walk_last;
      logic       alloc_fail;
      logic       next_zero;
      logic       out_last;
   } ctl_sts_type;

endpackage

/* rtl/core/pfa_datapath.sv */
// Frame table, scan index, counters and the result register.
`timescale 1ns / 1ps

module pfa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pfa_pkg::req_type     req_data,
   input  pfa_pkg::ctl_cmd_type cmd,
   output pfa_pkg::ctl_sts_type sts,
   output pfa_pkg::rsp_type     rsp_data
);

   logic [7:0]                  table_ff [pfa_pkg::FRAMES];
   logic [pfa_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [pfa_pkg::CNT_W-1:0]   free_ff, free_in;
   logic [pfa_pkg::WANT_W-1:0]  want_ff, want_in;
   logic [pfa_pkg::MASK_W-1:0]  mask_ff, mask_in;
   logic [7:0]                  num_ff, num_in;
   logic [7:0]                  next_ff, next_in;
   logic [7:0]                  pid_ff, pid_in;
   logic [1:0]                  op_ff, op_in;
   logic                        exh_ff, exh_in;
   pfa_pkg::rsp_type            rsp_ff, rsp_in;
   logic [7:0]                  cur_owner;
   logic                        wr_en;
   logic [7:0]                  wr_data;
   logic                        walk_last;
   logic                        dump_last;
   logic                        alloc_fail;

   assign cur_owner  = table_ff[idx_ff];
   assign walk_last  = (idx_ff == pfa_pkg::IDX_W'(pfa_pkg::FRAMES - 1));
   assign dump_last  = (idx_ff == pfa_pkg::IDX_W'(pfa_pkg::REPORTED - 1));
   assign alloc_fail = exh_ff ||
                       (pfa_pkg::CMP_W'(free_ff) < pfa_pkg::CMP_W'(want_ff));

   always_comb begin
      idx_in  = idx_ff;
      free_in = free_ff;
      want_in = want_ff;
      mask_in = mask_ff;
      num_in  = num_ff;
      next_in = next_ff;
      pid_in  = pid_ff;
      op_in   = op_ff;
      exh_in  = exh_ff;
      rsp_in  = rsp_ff;
      wr_en   = 1'b0;
      wr_data = 8'd0;

      if (cmd.capture) begin
         idx_in  = '0;
         free_in = '0;
         mask_in = '0;
         want_in = req_data.page_count;
         pid_in  = req_data.process_id;
         op_in   = req_data.command;
         exh_in  = (next_ff == 8'd0);
         num_in  = next_ff;
         if (req_data.command == pfa_pkg::CMD_ALLOC && next_ff != 8'd0) begin
            next_in = 8'(next_ff + 8'd1);
         end
      end

      if (cmd.count_step) begin
         if (cur_owner == 8'd0) begin
            free_in = pfa_pkg::CNT_W'(free_ff + 1'b1);
         end
         idx_in = walk_last ? '0 : pfa_pkg::IDX_W'(idx_ff + 1'b1);
      end

      if (cmd.walk_step) begin
         case (op_ff)
            pfa_pkg::CMD_ERASE: begin
               if (cur_owner == pid_ff) begin
                  wr_en   = 1'b1;
                  wr_data = 8'd0;
               end
            end
            pfa_pkg::CMD_ALLOC: begin
               if (cur_owner == 8'd0 && want_ff != '0) begin
                  wr_en   = 1'b1;
                  wr_data = num_ff;
                  want_in = pfa_pkg::WANT_W'(want_ff - 1'b1);
               end
            end
            pfa_pkg::CMD_LOCATE: begin
               // frames past the mask width shift out to nothing
               if (cur_owner == pid_ff) begin
                  mask_in = mask_ff | (pfa_pkg::MASK_W'(1) << idx_ff);
               end
            end
            default: begin
            end
         endcase
         idx_in = walk_last ? '0 : pfa_pkg::IDX_W'(idx_ff + 1'b1);
      end

      if (cmd.dump_load) begin
         rsp_in.status      = pfa_pkg::STATUS_OK;
         rsp_in.frame_index = 4'(idx_ff);
         rsp_in.owner       = cur_owner;
         rsp_in.frame_mask  = '0;
         rsp_in.last        = dump_last;
         idx_in = pfa_pkg::IDX_W'(idx_ff + 1'b1);
      end

      if (cmd.final_load) begin
         rsp_in.status      = pfa_pkg::STATUS_OK;
         rsp_in.frame_index = 4'd0;
         rsp_in.owner       = 8'd0;
         rsp_in.frame_mask  = '0;
         rsp_in.last        = 1'b1;
         case (op_ff)
            pfa_pkg::CMD_ALLOC: begin
               if (exh_ff) begin
                  rsp_in.status = pfa_pkg::STATUS_EXHAUSTED;
               end else if (alloc_fail) begin
                  rsp_in.status = pfa_pkg::STATUS_NO_SPACE;
               end else begin
                  rsp_in.owner = num_ff;
               end
            end
            pfa_pkg::CMD_LOCATE: begin
               rsp_in.frame_mask = mask_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pfa_pkg::FRAMES; i++) begin
            table_ff[i] <= 8'd0;
         end
         next_ff <= 8'd1;
      end else begin
         if (wr_en) begin
            table_ff[idx_ff] <= wr_data;
         end
         next_ff <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      free_ff <= free_in;
      want_ff <= want_in;
      mask_ff <= mask_in;
      num_ff  <= num_in;
      pid_ff  <= pid_in;
      op_ff   <= op_in;
      exh_ff  <= exh_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data       = rsp_ff;
   assign sts.walk_last  = walk_last;
   assign sts.alloc_fail = alloc_fail;
   assign sts.next_zero  = (next_ff == 8'd0);
   assign sts.out_last   = rsp_ff.last;

endmodule

/* rtl/core/pfa_controller.sv */
// Command sequencer: scan passes, dump beats and result handshake.
`timescale 1ns / 1ps

module pfa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pfa_pkg::ctl_sts_type sts,
   output pfa_pkg::ctl_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_COUNT = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_WALK  = 7'b0001000,
      ST_DUMP  = 7'b0010000,
      ST_FINAL = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_command)
                  pfa_pkg::CMD_DUMP:  state_in = ST_DUMP;
                  pfa_pkg::CMD_ALLOC: state_in = sts.next_zero ? ST_CHECK : ST_COUNT;
                  default:            state_in = ST_WALK;
               endcase
            end
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.alloc_fail ? ST_FINAL : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_DUMP: begin
            cmd.dump_load = 1'b1;
            state_in      = ST_OUT;
         end
         ST_FINAL: begin
            cmd.final_load = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = sts.out_last ? ST_IDLE : ST_DUMP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a beat is pending");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after a request beat");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sts.out_last) |=> req_ready)
      else $error("not idle after the last beat");

   a_check_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |->
         ($past(state_ff) == ST_COUNT || $past(state_ff) == ST_IDLE))
      else $error("allocation check entered out of order");

endmodule

/* rtl/core/page_frame_allocator.sv */
// Top level of the page frame allocator: controller plus datapath.
`timescale 1ns / 1ps

// Holds a 16-frame owner table (0 = free) and runs one command at a time; req_ready is high
// only when idle. Erase and locate walk the table one frame a cycle, load the result in the
// final state and then give one beat. Allocate first counts free frames and checks the count,
// then, if enough are free, fills the lowest free frames before the result load; a refused
// allocate answers after the check, and when process numbers are spent the count is skipped.
// Dump gives 16 beats, frame 0 first with last on the final one. Cost is set by the single
// table read port, one frame per cycle while scanning. The result register holds each beat
// until taken.

module page_frame_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfa_pkg::rsp_type rsp_data
);

   pfa_pkg::ctl_cmd_type cmd;
   pfa_pkg::ctl_sts_type sts;

   pfa_controller u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   pfa_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
